### hdl/rsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types, codes and the microprogram of the rotation speed profile.
// ----------------------------------------------------------------------------
package rsp_pkg;

    // pi in Q2.30, rounded to nearest at the working fraction width by the datapath
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam logic [15:0] RATE_MAX = 16'd32767;

    // configuration register indexes
    localparam logic [2:0] REG_GOAL_ANGLE    = 3'd0;
    localparam logic [2:0] REG_ACCEL         = 3'd1;
    localparam logic [2:0] REG_VELOCITY_STEP = 3'd2;
    localparam logic [2:0] REG_MAX_SPEED     = 3'd3;
    localparam logic [2:0] REG_MIN_SPEED     = 3'd4;

    // datapath operations
    localparam logic [2:0] OP_NOP       = 3'd0;
    localparam logic [2:0] OP_LOAD      = 3'd1;
    localparam logic [2:0] OP_WRAP_CHK  = 3'd2;
    localparam logic [2:0] OP_MOD_STEP  = 3'd3;
    localparam logic [2:0] OP_UNWRAP    = 3'd4;
    localparam logic [2:0] OP_MUL       = 3'd5;
    localparam logic [2:0] OP_SQRT_STEP = 3'd6;
    localparam logic [2:0] OP_FINISH    = 3'd7;

    // jump conditions
    localparam logic [2:0] COND_NONE     = 3'd0;
    localparam logic [2:0] COND_ALWAYS   = 3'd1;
    localparam logic [2:0] COND_NO_INPUT = 3'd2;
    localparam logic [2:0] COND_IN_RANGE = 3'd3;
    localparam logic [2:0] COND_CNT_NZ   = 3'd4;
    localparam logic [2:0] COND_OUT_FULL = 3'd5;

    // program steps
    localparam logic [2:0] STEP_IDLE   = 3'd0;
    localparam logic [2:0] STEP_WRAP   = 3'd1;
    localparam logic [2:0] STEP_MOD    = 3'd2;
    localparam logic [2:0] STEP_UNWRAP = 3'd3;
    localparam logic [2:0] STEP_MUL    = 3'd4;
    localparam logic [2:0] STEP_SQRT   = 3'd5;
    localparam logic [2:0] STEP_WAIT   = 3'd6;
    localparam logic [2:0] STEP_FINISH = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] cond;
        logic [2:0] target;
    } rsp_ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic in_range;
        logic cnt_nz;
        logic out_full;
    } rsp_stat_t;

    function automatic rsp_ctrl_t rsp_rom(input logic [2:0] pc);
        rsp_ctrl_t w;
        case (pc)
            STEP_IDLE:   w = '{op: OP_LOAD,      cond: COND_NO_INPUT, target: STEP_IDLE};
            STEP_WRAP:   w = '{op: OP_WRAP_CHK,  cond: COND_IN_RANGE, target: STEP_MUL};
            STEP_MOD:    w = '{op: OP_MOD_STEP,  cond: COND_CNT_NZ,   target: STEP_MOD};
            STEP_UNWRAP: w = '{op: OP_UNWRAP,    cond: COND_NONE,     target: STEP_IDLE};
            STEP_MUL:    w = '{op: OP_MUL,       cond: COND_NONE,     target: STEP_IDLE};
            STEP_SQRT:   w = '{op: OP_SQRT_STEP, cond: COND_CNT_NZ,   target: STEP_SQRT};
            STEP_WAIT:   w = '{op: OP_NOP,       cond: COND_OUT_FULL, target: STEP_WAIT};
            STEP_FINISH: w = '{op: OP_FINISH,    cond: COND_ALWAYS,   target: STEP_IDLE};
            default:     w = '{op: OP_NOP,       cond: COND_ALWAYS,   target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

### hdl/rotation_speed_profile.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_speed_profile
// Trapezoidal turn-rate profile toward a goal heading, microcoded.
// ----------------------------------------------------------------------------
// Each heading word gives one turn-rate word. One item is worked at a time:
// the error to the goal is loaded, wrapped by modulo steps and an unwrap
// when it lies outside [-pi, pi], scaled by the acceleration and passed
// through the 16-step bit-pair square root on the shared datapath before
// the limiter. The next heading is taken while a result still waits in
// the output register. Writing goal_angle clears the stored last speed.
module rotation_speed_profile #(
    parameter int FRAC_BITS = 13
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] heading
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] turn_rate
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import rsp_pkg::*;

    rsp_ctrl_t ctrl;
    rsp_stat_t stat;

    rsp_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    rsp_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_heading (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_rate   (m_axis_tdata)
    );

endmodule
`default_nettype wire

### hdl/rsp_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_seq
// Step counter and program table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module rsp_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rsp_pkg::rsp_stat_t stat,
    output rsp_pkg::rsp_ctrl_t      ctrl
);
    import rsp_pkg::*;

    logic [2:0] pc_reg;
    logic [2:0] pc_next;
    logic       take;

    assign ctrl = rsp_rom(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            COND_NONE:     take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_INPUT: take = !stat.in_valid;
            COND_IN_RANGE: take = stat.in_range;
            COND_CNT_NZ:   take = stat.cnt_nz;
            COND_OUT_FULL: take = stat.out_full;
            default:       take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

### hdl/rsp_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_dpath
// Datapath: settings, angle wrap, multiplier, bit-pair square root, limiter.
// ----------------------------------------------------------------------------
module rsp_dpath #(
    parameter int FRAC_BITS = 13
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rsp_pkg::rsp_ctrl_t ctrl,
    output rsp_pkg::rsp_stat_t      stat,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [15:0]        in_heading,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [15:0]             out_rate
);
    import rsp_pkg::*;

    localparam longint PI_Q      = longint'((PI_Q30 + (64'd1 << (29 - FRAC_BITS)))
                                            >> (30 - FRAC_BITS));
    localparam longint TWO_PI    = 2 * PI_Q;
    localparam longint WRAPS     = (65536 + TWO_PI - 1) / TWO_PI;
    localparam longint OFFSET    = PI_Q + WRAPS * TWO_PI;
    localparam longint X_MAX     = 65535 + OFFSET;
    localparam int     XW        = $clog2(X_MAX + 1);
    localparam int     MOD_STEPS = $clog2((X_MAX + TWO_PI) / TWO_PI);
    localparam int     CW        = $clog2((MOD_STEPS > 16) ? MOD_STEPS : 16);
    localparam int     SQRT_STEPS = 16;

    localparam logic signed [XW:0] PI_W     = (XW + 1)'(PI_Q);
    localparam logic signed [XW:0] OFFSET_W = (XW + 1)'(OFFSET);
    localparam logic [XW:0]        TWO_PI_W = (XW + 1)'(TWO_PI);

    // settings
    logic signed [15:0] goal_reg;
    logic [14:0]        accel_reg;
    logic [14:0]        vstep_reg;
    logic [14:0]        max_speed_reg;
    logic [14:0]        min_speed_reg;

    // working state
    logic signed [XW:0] work_reg,  work_next;
    logic [CW-1:0]      cnt_reg,   cnt_next;
    logic [31:0]        rem_reg,   rem_next;
    logic [31:0]        root_reg,  root_next;
    logic               neg_reg,   neg_next;
    logic               zero_reg,  zero_next;
    logic signed [15:0] last_reg,  last_next;
    logic               ovalid_reg, ovalid_next;
    logic [15:0]        orate_reg, orate_next;

    logic               in_range;
    logic [XW:0]        mod_sub;
    logic [15:0]        mag_err;
    logic [31:0]        sq_bit;
    logic [32:0]        sq_trial;
    logic [15:0]        last_mag;
    logic [16:0]        acc_mag;
    logic [16:0]        mag;
    logic [15:0]        rate;

    assign in_range = (work_reg <= PI_W) && (work_reg >= -PI_W);
    assign in_ready = (ctrl.op == OP_LOAD);
    assign mod_sub  = TWO_PI_W << cnt_reg;
    assign mag_err  = work_reg[XW] ? 16'(-work_reg) : work_reg[15:0];
    assign sq_bit   = 32'd1 << {cnt_reg, 1'b0};
    assign sq_trial = {1'b0, root_reg} + {1'b0, sq_bit};
    assign last_mag = last_reg[15] ? 16'(-last_reg) : 16'(last_reg);
    assign acc_mag  = {1'b0, last_mag} + {2'b00, vstep_reg};

    always_comb
    begin
        mag = {1'b0, root_reg[15:0]};
        if (acc_mag < mag)
            mag = acc_mag;
        if ({2'b00, max_speed_reg} < mag)
            mag = {2'b00, max_speed_reg};
        if (zero_reg)
            mag = '0;
        if ((mag != '0) && (mag < {2'b00, min_speed_reg}))
            mag = {2'b00, min_speed_reg};
        if (mag > {1'b0, RATE_MAX})
            mag = {1'b0, RATE_MAX};
        rate = neg_reg ? 16'(-mag) : mag[15:0];
    end

    always_comb
    begin
        work_next   = work_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;
        last_next   = last_reg;
        orate_next  = orate_reg;
        ovalid_next = ovalid_reg && !out_ready;
        case (ctrl.op)
            OP_LOAD:
            begin
                if (in_valid)
                    work_next = (XW + 1)'(goal_reg) - (XW + 1)'($signed(in_heading));
            end
            OP_WRAP_CHK:
            begin
                if (!in_range)
                begin
                    work_next = work_reg + OFFSET_W;
                    cnt_next  = CW'(MOD_STEPS - 1);
                end
            end
            OP_MOD_STEP:
            begin
                if ($unsigned(work_reg) >= mod_sub)
                    work_next = $signed($unsigned(work_reg) - mod_sub);
                cnt_next = cnt_reg - CW'(1);
            end
            OP_UNWRAP:
            begin
                work_next = work_reg - PI_W;
            end
            OP_MUL:
            begin
                rem_next  = {31'(accel_reg * mag_err), 1'b0};
                root_next = '0;
                cnt_next  = CW'(SQRT_STEPS - 1);
                neg_next  = work_reg[XW];
                zero_next = (work_reg == '0);
            end
            OP_SQRT_STEP:
            begin
                if ({1'b0, rem_reg} >= sq_trial)
                begin
                    rem_next  = rem_reg - sq_trial[31:0];
                    root_next = (root_reg >> 1) + sq_bit;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                cnt_next = cnt_reg - CW'(1);
            end
            OP_FINISH:
            begin
                last_next   = $signed(rate);
                orate_next  = rate;
                ovalid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (cfg_we && (cfg_index == REG_GOAL_ANGLE))
            last_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg      <= '0;
            accel_reg     <= 15'd8192;
            vstep_reg     <= 15'd819;
            max_speed_reg <= 15'd8192;
            min_speed_reg <= 15'd2703;
            last_reg      <= '0;
            ovalid_reg    <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
            cnt_reg    <= cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GOAL_ANGLE:    goal_reg      <= $signed(cfg_data);
                    REG_ACCEL:         accel_reg     <= cfg_data[14:0];
                    REG_VELOCITY_STEP: vstep_reg     <= cfg_data[14:0];
                    REG_MAX_SPEED:     max_speed_reg <= cfg_data[14:0];
                    REG_MIN_SPEED:     min_speed_reg <= cfg_data[14:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        orate_reg <= orate_next;
    end

    assign stat.in_valid = in_valid;
    assign stat.in_range = in_range;
    assign stat.cnt_nz   = (cnt_reg != '0);
    assign stat.out_full = ovalid_reg;

    assign out_valid = ovalid_reg;
    assign out_rate  = orate_reg;

endmodule
`default_nettype wire

### hdl/rsp_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_check
// Port-level checks for rotation_speed_profile, bound to the top level.
// ----------------------------------------------------------------------------
module rsp_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again while an item is in work");

    rate_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata != 16'h8000)
        else $error("turn rate beyond magnitude limit");

endmodule

bind rotation_speed_profile rsp_check u_rsp_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

### dv/rotation_speed_profile_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_speed_profile_tb
// Feeds heading words to the rotation speed profile and checks each turn
// rate word against a cycle-free model of the trapezoidal profile. A short
// directed table covers the angle wrap, zero error, the speed floor and the
// register extremes. Random phases then follow with headings that sweep
// toward the goal, under varied backpressure and source gaps.
// ----------------------------------------------------------------------------
module rotation_speed_profile_tb;

    import rsp_pkg::*;

    localparam int     FRAC_BITS     = 13;
    localparam longint HALF_TURN     =
        longint'((PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    localparam int     SETTLE_CYCLES = 40;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     PHASES        = 6;
    localparam int     PHASE_WORDS   = 250;
    localparam int     REPORT_CAP    = 100;

    localparam logic [2:0] IDX_NONE    = 3'd0;  // unused on heading rows
    localparam logic [2:0] REG_SPARE_5 = 3'd5;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    typedef enum logic {ROW_HEADING, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [15:0] word;
        logic        fixed;  // rate below is the known answer
        logic [15:0] rate;
    } stim_row_t;

    localparam int ROW_COUNT = 39;
    localparam stim_row_t STIM_ROWS [0:ROW_COUNT-1] = '{
        // reset settings: zero error, +-pi, raw error beyond the wrap, floor
        '{ROW_HEADING, IDX_NONE, 16'h0000, 1'b1, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h6488, 1'b1, 16'hF571},
        '{ROW_HEADING, IDX_NONE, 16'h9B78, 1'b1, 16'h0DC2},
        '{ROW_HEADING, IDX_NONE, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h8000, 1'b0, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'hFFFF, 1'b1, 16'h0A8F},
        '{ROW_HEADING, IDX_NONE, 16'h0001, 1'b1, 16'hF571},
        '{ROW_HEADING, IDX_NONE, 16'h9B77, 1'b0, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h9B78, 1'b0, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h9B78, 1'b0, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h9B78, 1'b0, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h9B78, 1'b0, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h9B78, 1'b0, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h9B78, 1'b0, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h5555, 1'b0, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'hAAAA, 1'b0, 16'h0000},
        // goal at +pi, all limits at top, no floor; spare indexes ignored
        '{ROW_WRITE, REG_GOAL_ANGLE,    16'h6488, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_ACCEL,         16'hFFFF, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_VELOCITY_STEP, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_MAX_SPEED,     16'h7FFF, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_MIN_SPEED,     16'h0000, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_SPARE_5,       16'h1234, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_SPARE_7,       16'hFFFF, 1'b0, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h9B78, 1'b1, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h6488, 1'b1, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h8000, 1'b0, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h0000, 1'b1, 16'h7FFF},
        // no acceleration: floor must not lift a zero magnitude
        '{ROW_WRITE, REG_GOAL_ANGLE,    16'h9B78, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_ACCEL,         16'h0000, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_MAX_SPEED,     16'h0000, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_MIN_SPEED,     16'hFFFF, 1'b0, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h0000, 1'b1, 16'h0000},
        '{ROW_WRITE, REG_ACCEL,         16'h7FFF, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_VELOCITY_STEP, 16'h0000, 1'b0, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h0000, 1'b1, 16'h0000},
        // floor above the cap
        '{ROW_WRITE, REG_VELOCITY_STEP, 16'h0001, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_MAX_SPEED,     16'h0005, 1'b0, 16'h0000},
        '{ROW_HEADING, IDX_NONE, 16'h0000, 1'b1, 16'h8001},
        '{ROW_HEADING, IDX_NONE, 16'h0000, 1'b0, 16'h0000}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_we        = 1'b0;
    logic [2:0]  cfg_index     = REG_GOAL_ANGLE;
    logic [15:0] cfg_data      = '0;

    // profile settings and state as the block should hold them
    logic signed [15:0] tgt_heading;
    logic [14:0]        accel_lim;
    logic [14:0]        step_gain;
    logic [14:0]        rate_cap;
    logic [14:0]        rate_floor;
    longint             prev_rate;

    logic [15:0] turn_rate_due[$];
    logic [15:0] due_rate;
    int          mismatches     = 0;
    int          cycle_count    = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    logic        pressure_go    = 1'b0;
    logic        hold_sink      = 1'b0;

    rotation_speed_profile #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    function automatic void load_reg(input logic [2:0] idx, input logic [15:0] word);
        case (idx)
            REG_GOAL_ANGLE:
            begin
                tgt_heading = word;
                prev_rate   = 0;
            end
            REG_ACCEL:         accel_lim  = word[14:0];
            REG_VELOCITY_STEP: step_gain  = word[14:0];
            REG_MAX_SPEED:     rate_cap   = word[14:0];
            REG_MIN_SPEED:     rate_floor = word[14:0];
            default: ;
        endcase
    endfunction

    function automatic logic [15:0] next_turn_rate(input logic [15:0] heading);
        longint          diff;
        longint          err;
        longint          rate;
        longint unsigned err_mag;
        longint unsigned stop_speed;
        longint unsigned ramp;
        longint unsigned mag;
        diff = longint'(tgt_heading) - longint'($signed(heading));
        if (diff > HALF_TURN || diff < -HALF_TURN)
        begin
            err = (diff + HALF_TURN) % (2 * HALF_TURN);
            if (err < 0)
                err += 2 * HALF_TURN;
            err -= HALF_TURN;
        end
        else
            err = diff;
        err_mag    = (err < 0) ? -err : err;
        stop_speed = floor_sqrt(64'd2 * accel_lim * err_mag);
        ramp       = ((prev_rate < 0) ? -prev_rate : prev_rate) + step_gain;
        mag        = stop_speed;
        if (ramp < mag)
            mag = ramp;
        if (rate_cap < mag)
            mag = rate_cap;
        if (err == 0)
            mag = 0;
        if (mag != 0 && mag < rate_floor)
            mag = rate_floor;
        if (mag > RATE_MAX)
            mag = RATE_MAX;
        rate      = (err < 0) ? -longint'(mag) : longint'(mag);
        prev_rate = rate;
        return rate[15:0];
    endfunction

    function automatic logic [15:0] cfg_word(input int small_max);
        logic [15:0] word;
        word = 16'($urandom);  // top bit is dropped by the block
        word[14:0] = ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(small_max));
        return word;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < REPORT_CAP)
            $display("%0t ERROR %s", $time, msg);
        mismatches++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] word);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        load_reg(idx, word);
    endtask

    task automatic push_heading(input logic [15:0] heading, input logic fixed,
                                input logic [15:0] known_rate);
        logic [15:0] predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= heading;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = next_turn_rate(heading);
        turn_rate_due.push_back(fixed ? known_rate : predicted);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (turn_rate_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_sink)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // long sink hold so the block backs up into its input
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_sink <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (turn_rate_due.size() == 0)
                report_mismatch($sformatf("turn rate word %h with nothing due", m_axis_tdata));
            else
            begin
                due_rate = turn_rate_due.pop_front();
                if (m_axis_tdata !== due_rate)
                    report_mismatch($sformatf("turn_rate %h, due %h", m_axis_tdata, due_rate));
            end
        end
    end

    initial
    begin
        row_kind_t   prev_kind;
        logic [15:0] heading;
        int          sweep;
        int          err_left;
        int          stride;
        int          pick;
        tgt_heading = '0;
        accel_lim   = 15'd8192;
        step_gain   = 15'd819;
        rate_cap    = 15'd8192;
        rate_floor  = 15'd2703;
        prev_rate   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        prev_kind = ROW_HEADING;
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            if (STIM_ROWS[i].kind == ROW_WRITE)
            begin
                if (prev_kind == ROW_HEADING)
                    settle();
                write_reg(STIM_ROWS[i].idx, STIM_ROWS[i].word);
            end
            else
            begin
                if (prev_kind == ROW_WRITE)
                    cfg_we <= 1'b0;
                push_heading(STIM_ROWS[i].word, STIM_ROWS[i].fixed, STIM_ROWS[i].rate);
            end
            prev_kind = STIM_ROWS[i].kind;
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_reg(REG_GOAL_ANGLE, 16'($urandom_range(51472) - 25736));
            write_reg(REG_ACCEL, cfg_word(2000));
            write_reg(REG_VELOCITY_STEP, cfg_word(1500));
            write_reg(REG_MAX_SPEED, cfg_word(12000));
            write_reg(REG_MIN_SPEED, cfg_word(4000));
            cfg_we <= 1'b0;
            case (p % 4)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 80;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 80;
                end
                default:
                begin
                    src_idle_pct   = 12;
                    sink_stall_pct = 12;
                end
            endcase
            if (p == 0)
                pressure_go = 1'b1;
            sweep = int'($urandom_range(51472)) - 25736;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 12)
                    heading = 16'($urandom);
                else if (pick < 22)
                    heading = 16'($urandom_range(51472) - 25736);
                else
                begin
                    // robot turning toward the goal, then parked on it
                    err_left = int'(tgt_heading) - sweep;
                    stride   = $urandom_range(900);
                    if (err_left == 0)
                    begin
                        if ($urandom_range(3) == 0)
                            sweep = int'($urandom_range(51472)) - 25736;
                    end
                    else if (err_left > stride || -err_left > stride)
                        sweep += (err_left > 0) ? stride : -stride;
                    else
                        sweep = int'(tgt_heading);
                    heading = 16'(sweep);
                end
                push_heading(heading, 1'b0, 16'h0000);
            end
        end

        settle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
hdl/rsp_pkg.sv
hdl/rsp_seq.sv
hdl/rsp_dpath.sv
hdl/rotation_speed_profile.sv
hdl/rsp_check.sv
dv/rotation_speed_profile_tb.sv
